// File: hw/rtl/spk_pkg.sv
// Shared types and constants for the Speck64/128 block cipher engine.
package spk_pkg;

    localparam int WORD_BITS = 32;
    localparam int KEY_WORDS = 4;
    localparam int ROT_A     = 8;
    localparam int ROT_B     = 3;
    localparam int CFG_IDX_W = 3;

    typedef logic [WORD_BITS-1:0] t_word;

    typedef enum logic [1:0] {
        CMD_ECB_ENC = 2'd0,
        CMD_ECB_DEC = 2'd1,
        CMD_CBC_ENC = 2'd2,
        CMD_CBC_DEC = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY_0 = 3'd0,
        REG_KEY_1 = 3'd1,
        REG_KEY_2 = 3'd2,
        REG_KEY_3 = 3'd3,
        REG_IV_X  = 3'd4,
        REG_IV_Y  = 3'd5
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXPAND,
        ST_FETCH,
        ST_ROUND,
        ST_FINISH
    } t_state;

    typedef struct packed {
        t_cmd  command;
        logic  chain_restart;
        t_word block_x;
        t_word block_y;
    } t_in;

    typedef struct packed {
        t_word out_x;
        t_word out_y;
    } t_out;

endpackage

// File: hw/rtl/speck_block_cipher_cbc.sv
// Speck64/128 engine with ECB and CBC modes, an encryption round that the key schedule
// shares, a decryption round and a round-key store. A request accepted with fresh round
// keys passes through the fetch, round and finish states; after a key write the first
// request also runs the key expansion first. Rounds run one per cycle; a new request
// is taken only when idle, while a finished block may still wait in the output register.
// Reset (synchronous, active low) clears keys, IVs and the chaining block to zero and marks
// the round keys stale; the round-key store itself is not cleared.
module speck_block_cipher_cbc #(
    parameter int ROUNDS = 27
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  spk_pkg::t_in                   i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output spk_pkg::t_out                  o_out_data,
    input  logic                           i_cfg_we,
    input  logic [spk_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  spk_pkg::t_word                 i_cfg_data
);

    localparam int RND_W = $clog2(ROUNDS);
    localparam logic [RND_W-1:0] LAST_RND = RND_W'(ROUNDS - 1);
    localparam logic [RND_W-1:0] ZERO_RND = '0;
    localparam int W  = spk_pkg::WORD_BITS;
    localparam int RA = spk_pkg::ROT_A;
    localparam int RB = spk_pkg::ROT_B;

    spk_pkg::t_state r_state, n_state;

    spk_pkg::t_word r_key [0:spk_pkg::KEY_WORDS-1];
    spk_pkg::t_word r_iv_x, r_iv_y;
    spk_pkg::t_word r_chain_x, r_chain_y;
    logic           r_keys_ready;
    logic [RND_W-1:0] r_rnd;
    logic           r_out_valid;
    spk_pkg::t_out  r_out;

    spk_pkg::t_cmd  r_cmd;
    spk_pkg::t_word r_a, r_b, r_px, r_py, r_k;
    spk_pkg::t_word r_lq [0:spk_pkg::KEY_WORDS-2];

    spk_pkg::t_word r_rk_mem [0:ROUNDS-1];
    spk_pkg::t_word r_rk_q;
    logic [RND_W-1:0] rd_addr;

    logic accept, out_load, dec_in, dec_r, rnd_last;
    logic [RND_W-1:0] first_in, first_r, next_rnd;
    spk_pkg::t_word chain_eff_x, chain_eff_y;
    spk_pkg::t_word u_a, u_b, u_key, u_sum, e_a, e_b, d_x, d_b, d_a;

    function automatic spk_pkg::t_word d_x_rot(input spk_pkg::t_word v);
        return {v[RB-1:0], v[W-1:RB]};
    endfunction

    assign accept   = i_in_valid && o_in_ready;
    assign dec_in   = (i_in_data.command == spk_pkg::CMD_ECB_DEC) ||
                      (i_in_data.command == spk_pkg::CMD_CBC_DEC);
    assign dec_r    = (r_cmd == spk_pkg::CMD_ECB_DEC) || (r_cmd == spk_pkg::CMD_CBC_DEC);
    assign first_in = dec_in ? LAST_RND : ZERO_RND;
    assign first_r  = dec_r ? LAST_RND : ZERO_RND;
    assign rnd_last = dec_r ? (r_rnd == ZERO_RND) : (r_rnd == LAST_RND);
    assign next_rnd = dec_r ? r_rnd - 1'b1 : r_rnd + 1'b1;
    assign out_load = (r_state == spk_pkg::ST_FINISH) && (!r_out_valid || i_out_ready);

    assign chain_eff_x = i_in_data.chain_restart ? r_iv_x : r_chain_x;
    assign chain_eff_y = i_in_data.chain_restart ? r_iv_y : r_chain_y;

    // The encryption round also serves the key schedule, with the round index as key.
    always_comb begin
        if (r_state == spk_pkg::ST_EXPAND) begin
            u_a   = r_lq[0];
            u_b   = r_k;
            u_key = W'(r_rnd);
        end else begin
            u_a   = r_a;
            u_b   = r_b;
            u_key = r_rk_q;
        end
        u_sum = {u_a[RA-1:0], u_a[W-1:RA]} + u_b;
        e_a   = u_sum ^ u_key;
        e_b   = {u_b[W-RB-1:0], u_b[W-1:W-RB]} ^ e_a;
        d_b   = {d_x_rot(r_a ^ r_b)};
        d_x   = (r_a ^ r_rk_q) - d_b;
        d_a   = {d_x[W-RA-1:0], d_x[W-1:W-RA]};
    end

    always_comb begin
        n_state = r_state;
        rd_addr = r_rnd;
        unique case (r_state)
            spk_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = r_keys_ready ? spk_pkg::ST_FETCH : spk_pkg::ST_EXPAND;
                end
            end
            spk_pkg::ST_EXPAND: begin
                if (r_rnd == LAST_RND) begin
                    n_state = spk_pkg::ST_FETCH;
                end
            end
            spk_pkg::ST_FETCH: begin
                n_state = spk_pkg::ST_ROUND;
            end
            spk_pkg::ST_ROUND: begin
                if (rnd_last) begin
                    n_state = spk_pkg::ST_FINISH;
                end else begin
                    rd_addr = next_rnd;
                end
            end
            spk_pkg::ST_FINISH: begin
                if (out_load) begin
                    n_state = spk_pkg::ST_IDLE;
                end
            end
            default: n_state = spk_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= spk_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready  = (r_state == spk_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Control and register state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < spk_pkg::KEY_WORDS; i++) begin
                r_key[i] <= '0;
            end
            r_iv_x       <= '0;
            r_iv_y       <= '0;
            r_chain_x    <= '0;
            r_chain_y    <= '0;
            r_keys_ready <= 1'b0;
            r_rnd        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    spk_pkg::REG_KEY_0: begin
                        r_key[0] <= i_cfg_data;
                        r_keys_ready <= 1'b0;
                    end
                    spk_pkg::REG_KEY_1: begin
                        r_key[1] <= i_cfg_data;
                        r_keys_ready <= 1'b0;
                    end
                    spk_pkg::REG_KEY_2: begin
                        r_key[2] <= i_cfg_data;
                        r_keys_ready <= 1'b0;
                    end
                    spk_pkg::REG_KEY_3: begin
                        r_key[3] <= i_cfg_data;
                        r_keys_ready <= 1'b0;
                    end
                    spk_pkg::REG_IV_X: begin
                        r_iv_x    <= i_cfg_data;
                        r_chain_x <= i_cfg_data;
                        r_chain_y <= r_iv_y;
                    end
                    spk_pkg::REG_IV_Y: begin
                        r_iv_y    <= i_cfg_data;
                        r_chain_x <= r_iv_x;
                        r_chain_y <= i_cfg_data;
                    end
                    default: ;
                endcase
            end

            if (accept) begin
                r_rnd <= r_keys_ready ? first_in : ZERO_RND;
                if (i_in_data.chain_restart) begin
                    r_chain_x <= r_iv_x;
                    r_chain_y <= r_iv_y;
                end
            end

            if (r_state == spk_pkg::ST_EXPAND) begin
                if (r_rnd == LAST_RND) begin
                    r_keys_ready <= 1'b1;
                    r_rnd        <= first_r;
                end else begin
                    r_rnd <= r_rnd + 1'b1;
                end
            end

            if (r_state == spk_pkg::ST_ROUND && !rnd_last) begin
                r_rnd <= next_rnd;
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
                if (r_cmd == spk_pkg::CMD_CBC_ENC) begin
                    r_chain_x <= r_a;
                    r_chain_y <= r_b;
                end else if (r_cmd == spk_pkg::CMD_CBC_DEC) begin
                    r_chain_x <= r_px;
                    r_chain_y <= r_py;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working words, key schedule queue and the result register.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_in_data.command;
            r_px  <= i_in_data.block_x;
            r_py  <= i_in_data.block_y;
            if (i_in_data.command == spk_pkg::CMD_CBC_ENC) begin
                r_a <= i_in_data.block_x ^ chain_eff_x;
                r_b <= i_in_data.block_y ^ chain_eff_y;
            end else begin
                r_a <= i_in_data.block_x;
                r_b <= i_in_data.block_y;
            end
            for (int i = 0; i < spk_pkg::KEY_WORDS - 1; i++) begin
                r_lq[i] <= r_key[spk_pkg::KEY_WORDS-2-i];
            end
            r_k <= r_key[spk_pkg::KEY_WORDS-1];
        end

        if (r_state == spk_pkg::ST_EXPAND) begin
            for (int i = 0; i < spk_pkg::KEY_WORDS - 2; i++) begin
                r_lq[i] <= r_lq[i+1];
            end
            r_lq[spk_pkg::KEY_WORDS-2] <= e_a;
            r_k <= e_b;
        end

        if (r_state == spk_pkg::ST_ROUND) begin
            if (dec_r) begin
                r_a <= d_a;
                r_b <= d_b;
            end else begin
                r_a <= e_a;
                r_b <= e_b;
            end
        end

        if (out_load) begin
            if (r_cmd == spk_pkg::CMD_CBC_DEC) begin
                r_out.out_x <= r_a ^ r_chain_x;
                r_out.out_y <= r_b ^ r_chain_y;
            end else begin
                r_out.out_x <= r_a;
                r_out.out_y <= r_b;
            end
        end
    end

    // Round-key store: written during expansion, read one round ahead.
    always_ff @(posedge i_clk) begin
        if (r_state == spk_pkg::ST_EXPAND) begin
            r_rk_mem[r_rnd] <= r_k;
        end
        r_rk_q <= r_rk_mem[rd_addr];
    end

`ifndef SYNTHESIS
    a_round_needs_keys: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == spk_pkg::ST_ROUND) |-> r_keys_ready)
        else $error("round started with stale round keys");

    a_expand_sets_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == spk_pkg::ST_EXPAND && r_rnd == LAST_RND) |=> r_keys_ready)
        else $error("key expansion finished without marking keys ready");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == spk_pkg::ST_FETCH || r_state == spk_pkg::ST_EXPAND))
        else $error("accepted request did not start processing");

    a_finish_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (r_out_valid && r_state == spk_pkg::ST_IDLE))
        else $error("finished block not placed in the output register");
`endif

endmodule
